// ----- hdl/cdsf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cdsf_pkg;

    // Fixed field widths of the item and result words.
    localparam int CH_BITS      = 4;
    localparam int SAMPLE_BITS  = 16;
    localparam int VALUE_BITS   = 24;
    localparam int MODE_BITS    = 2;
    localparam int ORDER_BITS   = 4;
    // Clamped order runs up to 15, the largest value of the four-bit order register.
    localparam int ORD_BITS     = 5;
    // Wide enough to compare a channel index against any supported channel count.
    localparam int CH_CMP_BITS  = 9;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = 4;

    // Operating modes.
    localparam logic [MODE_BITS-1:0] MODE_DIFF = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_SUM  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_ZERO = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_MODE  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORDER = 1'd1;

    // Item commands.
    localparam logic CMD_SAMPLE  = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef struct packed {
        logic                          command;
        logic [CH_BITS-1:0]            channel;
        logic signed [SAMPLE_BITS-1:0] sample;
    } item_t;

    typedef struct packed {
        logic [CH_BITS-1:0]           out_channel;
        logic signed [VALUE_BITS-1:0] value;
        logic                         settled;
    } result_t;

    // Word handed from cell to cell along the cascade.
    typedef struct packed {
        logic                         vld;
        logic [CH_BITS-1:0]           ch;
        logic                         hist;
        logic                         settled;
        logic signed [VALUE_BITS-1:0] now;
        logic signed [VALUE_BITS-1:0] res;
    } tok_t;

    // One stage operation: difference, pair sum or zero.
    function automatic logic signed [VALUE_BITS-1:0] combine(
        input logic [MODE_BITS-1:0]    mode,
        input logic signed [VALUE_BITS-1:0] a,
        input logic signed [VALUE_BITS-1:0] b
    );
        logic signed [VALUE_BITS-1:0] r;
        case (mode)
            MODE_DIFF: r = a - b;
            MODE_SUM:  r = a + b;
            MODE_ZERO: r = '0;
            default:   r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/cdsf_warm.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cdsf_warm #(
    parameter int CHANNELS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           adv,
    input  wire logic                           item_valid,
    input  wire cdsf_pkg::item_t                item,
    input  wire logic [cdsf_pkg::ORD_BITS-1:0]  ord,
    output cdsf_pkg::tok_t                      tok
);

    localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic                              vld_reg;
    cdsf_pkg::item_t                   item_reg;
    logic [cdsf_pkg::ORDER_BITS-1:0]   warm_mem [CHANNELS];
    logic [cdsf_pkg::ORDER_BITS-1:0]   warm_rd_reg;
    logic [CHANNELS-1:0]               settled_reg;
    logic [CHANNELS-1:0]               wvld_reg;
    logic [CHANNELS-1:0]               hist_reg;

    logic [CH_AW-1:0]                  rd_addr;
    logic [CH_AW-1:0]                  addr;
    logic                              is_restart;
    logic                              ch_ok;
    logic                              sample_ok;
    logic                              was_settled;
    logic [cdsf_pkg::ORDER_BITS-1:0]   wc;
    logic                              wc_done;
    logic                              wr_en;
    logic [cdsf_pkg::ORDER_BITS-1:0]   wr_data;

    assign rd_addr    = CH_AW'(item.channel);
    assign addr       = CH_AW'(item_reg.channel);
    assign is_restart = (item_reg.command == cdsf_pkg::CMD_RESTART);
    assign ch_ok      = cdsf_pkg::CH_CMP_BITS'(item_reg.channel)
                        < cdsf_pkg::CH_CMP_BITS'(CHANNELS);
    assign sample_ok  = vld_reg && !is_restart && ch_ok;

    // Warm-up bookkeeping for the channel of the word in this stage.
    always_comb
    begin
        was_settled = settled_reg[addr];
        wc          = wvld_reg[addr] ? warm_rd_reg : '0;
        wc_done     = cdsf_pkg::ORD_BITS'(wc) >= ord;
        wr_en       = adv && sample_ok && !was_settled && !wc_done;
        wr_data     = wc + cdsf_pkg::ORDER_BITS'(1);
    end

    // Stage register for the accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg <= item;
        end
    end

    // Warm-up counters, read with the next word's channel and written first.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            warm_mem[addr] <= wr_data;
        end
        if (adv)
        begin
            if (wr_en && (rd_addr == addr))
            begin
                warm_rd_reg <= wr_data;
            end
            else
            begin
                warm_rd_reg <= warm_mem[rd_addr];
            end
        end
    end

    // Per-channel flags; a restart clears warm-up for all channels at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settled_reg <= '0;
            wvld_reg    <= '0;
            hist_reg    <= '0;
        end
        else if (adv && vld_reg && is_restart)
        begin
            settled_reg <= '0;
            wvld_reg    <= '0;
        end
        else if (adv && sample_ok)
        begin
            hist_reg[addr] <= 1'b1;
            if (!was_settled)
            begin
                if (wc_done)
                begin
                    settled_reg[addr] <= 1'b1;
                end
                else
                begin
                    wvld_reg[addr] <= 1'b1;
                end
            end
        end
    end

    // The sample enters the cascade as stage zero.
    always_comb
    begin
        tok.vld     = sample_ok;
        tok.ch      = item_reg.channel;
        tok.hist    = hist_reg[addr];
        tok.settled = was_settled;
        tok.now     = cdsf_pkg::VALUE_BITS'($signed(item_reg.sample));
        tok.res     = '0;
    end

endmodule

`default_nettype wire

// ----- hdl/cdsf_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cdsf_cell #(
    parameter int CHANNELS = 16,
    parameter int IDX      = 0
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            adv,
    input  wire logic [cdsf_pkg::MODE_BITS-1:0]  mode,
    input  wire logic [cdsf_pkg::ORD_BITS-1:0]   ord,
    input  wire cdsf_pkg::tok_t                  tok_in,
    output cdsf_pkg::tok_t                       tok_out
);

    localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic                                   vld_reg;
    cdsf_pkg::tok_t                         tok_reg;
    logic signed [cdsf_pkg::VALUE_BITS-1:0] prev_mem [CHANNELS];
    logic signed [cdsf_pkg::VALUE_BITS-1:0] prev_rd_reg;

    logic [CH_AW-1:0]                       rd_addr;
    logic [CH_AW-1:0]                       wr_addr;
    logic                                   wr_en;
    logic signed [cdsf_pkg::VALUE_BITS-1:0] prev;
    logic signed [cdsf_pkg::VALUE_BITS-1:0] comb_val;

    assign rd_addr = CH_AW'(tok_in.ch);
    assign wr_addr = CH_AW'(tok_reg.ch);
    assign wr_en   = adv && vld_reg;

    // Stage register holding the word now at this cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= tok_in.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tok_reg <= tok_in;
        end
    end

    // This stage's previous value per channel, written first on a collision.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            prev_mem[wr_addr] <= tok_reg.now;
        end
        if (adv)
        begin
            if (wr_en && (rd_addr == wr_addr))
            begin
                prev_rd_reg <= tok_reg.now;
            end
            else
            begin
                prev_rd_reg <= prev_mem[rd_addr];
            end
        end
    end

    // A channel never seen before reads its previous value as zero.
    always_comb
    begin
        prev     = tok_reg.hist ? prev_rd_reg : '0;
        comb_val = cdsf_pkg::combine(mode, tok_reg.now, prev);
    end

    // Hand the next stage value on; the last active stage captures the result.
    always_comb
    begin
        tok_out     = tok_reg;
        tok_out.vld = vld_reg;
        tok_out.now = comb_val;
        if (ord == cdsf_pkg::ORD_BITS'(IDX + 1))
        begin
            tok_out.res = comb_val;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/cascaded_difference_sum_filter.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Multichannel cascaded difference / pair-sum filter. Each sample word runs
// through a warm-up stage and then a chain of MAX_ORDER identical cells, one
// per cascade stage; each cell keeps that stage's previous value for every
// channel in a small memory and hands the next stage value to its neighbor.
// A word passes the warm-up stage, each cell's register and then the result
// register, and the chain takes a new word every cycle while the result side
// is ready, so the rate is one word per cycle, set by the per-cell memory
// read-modify-write. A restart word clears warm-up for all channels and gives
// no result; words for channels at or above CHANNELS give none either. Stored
// stage values start at zero through per-channel flags, so no clearing pass
// follows reset. Write mode and order only while the block is idle.
module cascaded_difference_sum_filter #(
    parameter int CHANNELS  = 16,
    parameter int MAX_ORDER = 8
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 item_valid,
    output logic                                      item_ready,
    input  wire cdsf_pkg::item_t                      item,
    output logic                                      result_valid,
    input  wire logic                                 result_ready,
    output cdsf_pkg::result_t                         result,
    input  wire logic                                 cfg_we,
    input  wire logic [cdsf_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [cdsf_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    logic [cdsf_pkg::MODE_BITS-1:0]  mode_reg;
    logic [cdsf_pkg::ORDER_BITS-1:0] order_reg;
    logic [cdsf_pkg::ORD_BITS-1:0]   ord;
    logic                            adv;
    logic                            result_valid_reg;
    cdsf_pkg::result_t               result_reg;
    cdsf_pkg::tok_t                  tok_chain [MAX_ORDER + 1];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= cdsf_pkg::MODE_DIFF;
            order_reg <= cdsf_pkg::ORDER_BITS'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cdsf_pkg::REG_MODE:  mode_reg  <= cfg_data[cdsf_pkg::MODE_BITS-1:0];
                cdsf_pkg::REG_ORDER: order_reg <= cfg_data[cdsf_pkg::ORDER_BITS-1:0];
                default:             ;
            endcase
        end
    end

    // Order clamped to the supported cascade depth.
    always_comb
    begin
        if (order_reg == '0)
        begin
            ord = cdsf_pkg::ORD_BITS'(1);
        end
        else if (cdsf_pkg::ORD_BITS'(order_reg) > cdsf_pkg::ORD_BITS'(MAX_ORDER))
        begin
            ord = cdsf_pkg::ORD_BITS'(MAX_ORDER);
        end
        else
        begin
            ord = cdsf_pkg::ORD_BITS'(order_reg);
        end
    end

    // The whole chain moves whenever the result register can take a word.
    assign adv        = !result_valid_reg || result_ready;
    assign item_ready = adv;

    cdsf_warm #(
        .CHANNELS (CHANNELS)
    ) u_warm (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .item_valid (item_valid),
        .item       (item),
        .ord        (ord),
        .tok        (tok_chain[0])
    );

    for (genvar j = 0; j < MAX_ORDER; j++)
    begin : g_cell
        cdsf_cell #(
            .CHANNELS (CHANNELS),
            .IDX      (j)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .mode    (mode_reg),
            .ord     (ord),
            .tok_in  (tok_chain[j]),
            .tok_out (tok_chain[j + 1])
        );
    end

    // Result register; warm-up words report zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            result_valid_reg <= tok_chain[MAX_ORDER].vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg.out_channel <= tok_chain[MAX_ORDER].ch;
            result_reg.value       <= tok_chain[MAX_ORDER].settled
                                      ? tok_chain[MAX_ORDER].res : '0;
            result_reg.settled     <= tok_chain[MAX_ORDER].settled;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire
